// ===== sv/sdspi_pkg.sv =====
// Shared types, constants and sequence tables for the SD SPI-mode host sequencer.
package sdspi_pkg;

  localparam int unsigned SECTOR_BYTES = 512;

  // operation codes carried by a start request
  localparam logic [2:0] OP_RESET = 3'd0;
  localparam logic [2:0] OP_CHECK = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;

  // request kinds
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // card reply codes and fixed bytes
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] BYTE_IDLE   = 8'hff;
  localparam logic [7:0] TOKEN_START = 8'hfe;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd50;

  typedef logic [9:0] count_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WARM, PH_CMD0, PH_R0, PH_CMD8, PH_R8, PH_GAP9, PH_CMD58,
    PH_R58, PH_OCR, PH_PRE3, PH_CMD55, PH_R55, PH_ACMD41, PH_R41, PH_LEAD,
    PH_CMD24, PH_R24, PH_GAP5, PH_TOKEN, PH_WDATA, PH_WCRC, PH_BUSY, PH_CMD17,
    PH_R17, PH_WAITFE, PH_RDATA, PH_RCRC, PH_TAIL1, PH_TAIL2
  } phase_t;

  // one result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_low;
    logic       data_request;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       rd_last;
    logic       done_res;
    logic [7:0] result_byte;
    logic       busy_res;
  } rsp_t;

  // length of a counted phase; zero marks a polling phase
  function automatic count_t ph_len(phase_t ph, count_t startup);
    count_t len;
    unique case (ph)
      PH_WARM:                                  len = startup;
      PH_CMD0, PH_CMD8, PH_CMD58, PH_CMD55,
      PH_ACMD41, PH_CMD24, PH_CMD17:            len = count_t'(6);
      PH_GAP9:                                  len = count_t'(9);
      PH_OCR:                                   len = count_t'(8);
      PH_PRE3:                                  len = count_t'(3);
      PH_LEAD, PH_TOKEN, PH_TAIL1:              len = count_t'(1);
      PH_GAP5:                                  len = count_t'(5);
      PH_WDATA, PH_RDATA:                       len = count_t'(SECTOR_BYTES);
      PH_WCRC, PH_RCRC, PH_TAIL2:               len = count_t'(2);
      default:                                  len = '0;
    endcase
    return len;
  endfunction

  // phase that follows a counted phase
  function automatic phase_t ph_next(phase_t ph);
    phase_t nx;
    unique case (ph)
      PH_WARM:   nx = PH_CMD0;
      PH_CMD0:   nx = PH_R0;
      PH_CMD8:   nx = PH_R8;
      PH_GAP9:   nx = PH_CMD58;
      PH_CMD58:  nx = PH_R58;
      PH_OCR:    nx = PH_TAIL1;
      PH_PRE3:   nx = PH_CMD55;
      PH_CMD55:  nx = PH_R55;
      PH_ACMD41: nx = PH_R41;
      PH_LEAD:   nx = PH_CMD24;
      PH_CMD24:  nx = PH_R24;
      PH_GAP5:   nx = PH_TOKEN;
      PH_TOKEN:  nx = PH_WDATA;
      PH_WDATA:  nx = PH_WCRC;
      PH_WCRC:   nx = PH_BUSY;
      PH_CMD17:  nx = PH_R17;
      PH_RDATA:  nx = PH_RCRC;
      PH_RCRC:   nx = PH_TAIL1;
      default:   nx = PH_IDLE;
    endcase
    return nx;
  endfunction

  // card is selected in every phase but the idle clocking phases
  function automatic logic cs_of(phase_t ph);
    return !(ph == PH_IDLE || ph == PH_WARM || ph == PH_GAP9 ||
             ph == PH_PRE3 || ph == PH_TAIL1 || ph == PH_TAIL2);
  endfunction

  // bytes of the commands without an address argument
  function automatic logic [7:0] cmd_byte(phase_t ph, logic [2:0] j);
    logic [7:0] b;
    b = BYTE_IDLE;
    unique case (ph)
      PH_CMD0: begin
        case (j)
          3'd0:    b = 8'h40;
          3'd5:    b = 8'h95;
          default: b = 8'h00;
        endcase
      end
      PH_CMD8: begin
        case (j)
          3'd0:    b = 8'h48;
          3'd3:    b = 8'h01;
          3'd4:    b = 8'haa;
          3'd5:    b = 8'h87;
          default: b = 8'h00;
        endcase
      end
      PH_CMD58: begin
        case (j)
          3'd0:    b = 8'h7a;
          3'd5:    b = BYTE_IDLE;
          default: b = 8'h00;
        endcase
      end
      PH_CMD55: begin
        case (j)
          3'd0:    b = 8'h77;
          3'd5:    b = BYTE_IDLE;
          default: b = 8'h00;
        endcase
      end
      PH_ACMD41: begin
        case (j)
          3'd0:    b = 8'h69;
          3'd1:    b = 8'h40;
          3'd5:    b = BYTE_IDLE;
          default: b = 8'h00;
        endcase
      end
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/sdspi_fsm.sv =====
// Sequencer state and the one-pass decision for each request.
module sdspi_fsm #(
  parameter int STARTUP_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              func,
  input  logic [2:0]        op,
  input  logic [22:0]       sector,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        wr_byte,
  input  logic [7:0]        poll_limit,
  output sdspi_pkg::rsp_t   rsp
);
  import sdspi_pkg::*;

  localparam count_t STARTUP = count_t'(STARTUP_BYTES);

  phase_t      phase, phase_next;
  logic [2:0]  cur_op, cur_op_next;
  count_t      byte_count, byte_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [22:0] sector_q, sector_q_next;
  logic [7:0]  last_reply, last_reply_next;

  // decision flags handed to the output block
  logic   emit, busy_only, done, rdv, rdl;
  count_t len, cnt1;
  logic [7:0] pc1;
  logic   poll_end;

  assign len      = ph_len(phase, STARTUP);
  assign cnt1     = byte_count + count_t'(1);
  assign pc1      = poll_count + 8'd1;
  assign poll_end = (pc1 >= poll_limit);

  // next state
  always_comb begin
    phase_next      = phase;
    cur_op_next     = cur_op;
    byte_count_next = byte_count;
    poll_count_next = poll_count;
    sector_q_next   = sector_q;
    last_reply_next = last_reply;
    emit      = 1'b0;
    busy_only = 1'b0;
    done      = 1'b0;
    rdv       = 1'b0;
    rdl       = 1'b0;
    if (func == FUNC_START) begin
      if (phase != PH_IDLE) begin
        busy_only = 1'b1;
      end else if (op <= OP_WRITE) begin
        cur_op_next     = op;
        sector_q_next   = sector;
        last_reply_next = '0;
        byte_count_next = '0;
        poll_count_next = '0;
        emit            = 1'b1;
        unique case (op)
          OP_RESET: phase_next = PH_WARM;
          OP_CHECK: phase_next = PH_CMD8;
          OP_INIT:  phase_next = PH_PRE3;
          OP_READ:  phase_next = PH_CMD17;
          default:  phase_next = PH_LEAD;
        endcase
      end
    end else if (phase != PH_IDLE) begin
      if (len != '0) begin
        // counted phase
        if (phase == PH_OCR) last_reply_next = rx_byte;
        if (phase == PH_RDATA) begin
          rdv = 1'b1;
          rdl = (byte_count == count_t'(SECTOR_BYTES - 1));
        end
        if (cnt1 >= len) begin
          phase_next      = ph_next(phase);
          byte_count_next = '0;
          poll_count_next = '0;
          if (ph_next(phase) == PH_IDLE) done = 1'b1;
          else emit = 1'b1;
        end else begin
          byte_count_next = cnt1;
          emit            = 1'b1;
        end
      end else begin
        // polling phase: a phase change clears both counters
        emit = 1'b1;
        unique case (phase)
          PH_R0:
            if (rx_byte == R1_IDLE) phase_next = PH_TAIL2;
          PH_R8:
            if (rx_byte == R1_IDLE) phase_next = PH_GAP9;
          PH_R58:
            if (rx_byte != BYTE_IDLE) phase_next = PH_OCR;
          PH_R24:
            if (rx_byte == R1_READY) phase_next = PH_GAP5;
          PH_BUSY:
            if (rx_byte == BYTE_IDLE) phase_next = PH_TAIL2;
          PH_WAITFE:
            if (rx_byte == TOKEN_START) phase_next = PH_RDATA;
          PH_R55: begin
            poll_count_next = pc1;
            if (poll_end || rx_byte == R1_IDLE) phase_next = PH_ACMD41;
          end
          PH_R41: begin
            if (rx_byte == R1_READY) begin
              phase_next = PH_TAIL2;
            end else begin
              poll_count_next = pc1;
              if (poll_end) phase_next = PH_CMD55;
            end
          end
          PH_R17: begin
            poll_count_next = pc1;
            if (poll_end || rx_byte != BYTE_IDLE)
              phase_next = (rx_byte == R1_READY) ? PH_WAITFE : PH_CMD17;
          end
          default: begin
            phase_next = PH_IDLE;
            emit       = 1'b0;
          end
        endcase
        if (phase_next != phase) begin
          byte_count_next = '0;
          poll_count_next = '0;
        end
      end
    end
  end

  // result item
  always_comb begin
    logic [2:0] j;
    logic [7:0] tx;
    j  = (byte_count_next < count_t'(6)) ? byte_count_next[2:0] : 3'd5;
    tx = BYTE_IDLE;
    unique case (phase_next)
      PH_CMD24, PH_CMD17: begin
        case (j)
          3'd0:    tx = (phase_next == PH_CMD24) ? 8'h58 : 8'h51;
          3'd1:    tx = sector_q_next[22:15];
          3'd2:    tx = sector_q_next[14:7];
          3'd3:    tx = {sector_q_next[6:0], 1'b0};
          3'd4:    tx = 8'h00;
          default: tx = BYTE_IDLE;
        endcase
      end
      PH_TOKEN: tx = TOKEN_START;
      PH_WDATA: tx = wr_byte;
      default:  tx = cmd_byte(phase_next, j);
    endcase

    rsp = '0;
    if (emit) begin
      rsp.tx_valid     = 1'b1;
      rsp.tx_byte      = tx;
      rsp.cs_low       = cs_of(phase_next);
      rsp.data_request = (phase_next == PH_TOKEN) ||
                         (phase_next == PH_WDATA &&
                          byte_count_next < count_t'(SECTOR_BYTES - 1));
      rsp.busy_res     = 1'b1;
      rsp.rd_valid     = rdv;
      rsp.rd_byte      = rdv ? rx_byte : 8'h00;
      rsp.rd_last      = rdl;
    end else if (busy_only) begin
      rsp.cs_low   = cs_of(phase);
      rsp.busy_res = 1'b1;
    end else if (done) begin
      rsp.done_res    = 1'b1;
      rsp.result_byte = (cur_op == OP_CHECK) ? last_reply : 8'h00;
    end
  end

  // state registers, updated once per processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      cur_op     <= '0;
      byte_count <= '0;
      poll_count <= '0;
      sector_q   <= '0;
      last_reply <= '0;
    end else if (en) begin
      phase      <= phase_next;
      cur_op     <= cur_op_next;
      byte_count <= byte_count_next;
      poll_count <= poll_count_next;
      sector_q   <= sector_q_next;
      last_reply <= last_reply_next;
    end
  end

`ifndef SYNTHESIS
  // a finished operation leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    en && rsp.done_res |=> phase == PH_IDLE)
    else $error("done without returning to idle");

  // a start is only taken from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    en && func == FUNC_START && $past(1'b1) && phase != PH_IDLE |=> $stable(cur_op))
    else $error("start accepted while busy");

  // read data only while the card is selected and exchanging
  a_rd_cs: assert property (@(posedge clk) disable iff (rst)
    rsp.rd_valid |-> rsp.cs_low && rsp.tx_valid && rsp.busy_res)
    else $error("read data outside a selected exchange");
`endif

endmodule

// ===== sv/sd_card_spi_mode_host_sequencer.sv =====
// Top level: request register, sequencer, result register and poll limit register.
//
//  channel   valid      stall      payload
//  request   req_valid  req_stall  func, op, sector, rx_byte, wr_byte
//  result    rsp_valid  rsp_stall  tx_valid .. busy_res
//  config    cfg_we     -          cfg_data (poll_limit)
//
// One request per cycle while the result is not stalled; each request passes through
// the request register, then the result register. The sequencer state moves
// when a request passes from the request register into the result register.
// rst is synchronous: idle, poll limit back to 50. A stalled result holds the
// result register; the request register still takes one more request.
module sd_card_spi_mode_host_sequencer #(
  parameter int STARTUP_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        func,
  input  logic [2:0]  op,
  input  logic [22:0] sector,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  wr_byte,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        cs_low,
  output logic        data_request,
  output logic        rd_valid,
  output logic [7:0]  rd_byte,
  output logic        rd_last,
  output logic        done_res,
  output logic [7:0]  result_byte,
  output logic        busy_res,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import sdspi_pkg::*;

  logic        s1_valid;
  logic        s1_func;
  logic [2:0]  s1_op;
  logic [22:0] s1_sector;
  logic [7:0]  s1_rx;
  logic [7:0]  s1_wr;
  logic [7:0]  poll_limit;
  logic        adv;
  logic        take;
  rsp_t        rsp_comb, rsp_q;

  // handshake: the request register moves on whenever the result slot frees
  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;
  assign take      = req_valid && !req_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit <= cfg_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_func   <= func;
      s1_op     <= op;
      s1_sector <= sector;
      s1_rx     <= rx_byte;
      s1_wr     <= wr_byte;
    end
  end

  sdspi_fsm #(
    .STARTUP_BYTES(STARTUP_BYTES)
  ) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .func       (s1_func),
    .op         (s1_op),
    .sector     (s1_sector),
    .rx_byte    (s1_rx),
    .wr_byte    (s1_wr),
    .poll_limit (poll_limit),
    .rsp        (rsp_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_q <= rsp_comb;
    end
  end

  assign tx_valid     = rsp_q.tx_valid;
  assign tx_byte      = rsp_q.tx_byte;
  assign cs_low       = rsp_q.cs_low;
  assign data_request = rsp_q.data_request;
  assign rd_valid     = rsp_q.rd_valid;
  assign rd_byte      = rsp_q.rd_byte;
  assign rd_last      = rsp_q.rd_last;
  assign done_res     = rsp_q.done_res;
  assign result_byte  = rsp_q.result_byte;
  assign busy_res     = rsp_q.busy_res;

`ifndef SYNTHESIS
  // a processed request always lands in the result register
  a_adv_rsp: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp_valid)
    else $error("processed request lost");

  // request side stalls only with a full request register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("request stalled without cause");

  // a done result ends the operation
  a_done_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && done_res |-> !busy_res && !tx_valid && !rd_valid)
    else $error("done result marked busy");

  // write data is only asked for inside a selected exchange
  a_dreq_cs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && data_request |-> cs_low && tx_valid)
    else $error("data request outside an exchange");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the SD SPI-mode host sequencer with an emulated card.
`timescale 1ns / 1ps

module tb_top;
  import sdspi_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int WARM_BYTES   = 16;
  localparam int ITEMS        = 1250;
  localparam int NUM_SETTINGS = 6;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 40;

  // op codes with no operation behind them
  localparam logic [2:0] OP_NONE_FIRST = 3'd5;
  localparam logic [2:0] OP_NONE_LAST  = 3'd7;
  localparam logic [9:0] LAST_DATA     = 10'(SECTOR_BYTES - 1);

  // poll limit for each stretch of random traffic; the last one is drawn at random
  localparam logic [7:0] LIMIT_STEPS [NUM_SETTINGS] =
    '{8'd255, 8'd0, 8'd1, 8'd2, POLL_LIMIT_RESET, 8'd0};

  typedef struct packed {
    logic        func;
    logic [2:0]  op;
    logic [22:0] sector;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } host_req_t;

  typedef struct {
    host_req_t rq;
    bit        typed;
    rsp_t      want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        func = FUNC_START;
  logic [2:0]  op = OP_RESET;
  logic [22:0] sector = '0;
  logic [7:0]  rx_byte = '0;
  logic [7:0]  wr_byte = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        cs_low;
  logic        data_request;
  logic        rd_valid;
  logic [7:0]  rd_byte;
  logic        rd_last;
  logic        done_res;
  logic [7:0]  result_byte;
  logic        busy_res;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;

  // predicted sequencer state
  logic [7:0]  model_poll_limit = POLL_LIMIT_RESET;
  logic [2:0]  seq_op = OP_RESET;
  phase_t      seq_phase = PH_IDLE;
  logic [9:0]  seq_count = '0;
  logic [7:0]  seq_polls = '0;
  logic [31:0] seq_addr = '0;
  logic [7:0]  ocr_last = '0;

  rsp_t        host_out_q [$];
  step_row_t   rows [$];
  int          fed_items = 0;
  int          burst_left = 0;
  int          mismatch_count = 0;
  int          result_no = 0;
  int          stall_left = 0;
  int          stall_pct = 0;

  sd_card_spi_mode_host_sequencer #(.STARTUP_BYTES(WARM_BYTES)) u_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // bytes in a counted phase; zero marks a polling phase
  function automatic logic [9:0] step_len(phase_t p);
    case (p)
      PH_WARM:                             return 10'(WARM_BYTES);
      PH_CMD0, PH_CMD8, PH_CMD58, PH_CMD55,
      PH_ACMD41, PH_CMD24, PH_CMD17:       return 10'd6;
      PH_GAP9:                             return 10'd9;
      PH_OCR:                              return 10'd8;
      PH_PRE3:                             return 10'd3;
      PH_LEAD, PH_TOKEN, PH_TAIL1:         return 10'd1;
      PH_GAP5:                             return 10'd5;
      PH_WDATA, PH_RDATA:                  return 10'(SECTOR_BYTES);
      PH_WCRC, PH_RCRC, PH_TAIL2:          return 10'd2;
      default:                             return 10'd0;
    endcase
  endfunction

  function automatic phase_t step_after(phase_t p);
    case (p)
      PH_WARM:   return PH_CMD0;
      PH_CMD0:   return PH_R0;
      PH_CMD8:   return PH_R8;
      PH_GAP9:   return PH_CMD58;
      PH_CMD58:  return PH_R58;
      PH_OCR:    return PH_TAIL1;
      PH_PRE3:   return PH_CMD55;
      PH_CMD55:  return PH_R55;
      PH_ACMD41: return PH_R41;
      PH_LEAD:   return PH_CMD24;
      PH_CMD24:  return PH_R24;
      PH_GAP5:   return PH_TOKEN;
      PH_TOKEN:  return PH_WDATA;
      PH_WDATA:  return PH_WCRC;
      PH_WCRC:   return PH_BUSY;
      PH_CMD17:  return PH_R17;
      PH_RDATA:  return PH_RCRC;
      PH_RCRC:   return PH_TAIL1;
      default:   return PH_IDLE;
    endcase
  endfunction

  // chip select is released only while clocking idle bytes
  function automatic logic card_selected(phase_t p);
    return !(p inside {PH_IDLE, PH_WARM, PH_GAP9, PH_PRE3, PH_TAIL1, PH_TAIL2});
  endfunction

  // byte shifted out in phase p at position k
  function automatic logic [7:0] out_byte(phase_t p, logic [9:0] k, logic [31:0] addr,
                                          logic [7:0] wr);
    logic [47:0] frame;
    int          j;
    j = (k < 10'd6) ? int'(k) : 5;
    case (p)
      PH_CMD0:   frame = 48'h40_0000_0000_95;
      PH_CMD8:   frame = 48'h48_0000_01aa_87;
      PH_CMD58:  frame = 48'h7a_0000_0000_ff;
      PH_CMD55:  frame = 48'h77_0000_0000_ff;
      PH_ACMD41: frame = 48'h69_4000_0000_ff;
      PH_CMD24:  frame = {8'h58, addr, BYTE_IDLE};
      PH_CMD17:  frame = {8'h51, addr, BYTE_IDLE};
      PH_TOKEN:  return TOKEN_START;
      PH_WDATA:  return wr;
      default:   return BYTE_IDLE;
    endcase
    return frame[47 - 8 * j -: 8];
  endfunction

  task automatic enter_phase(phase_t p);
    seq_phase = p;
    seq_count = '0;
    seq_polls = '0;
  endtask

  // one more reply poll; a limit of zero still allows one
  function automatic bit poll_spent();
    seq_polls = seq_polls + 8'd1;
    return seq_polls >= model_poll_limit;
  endfunction

  // advance the sequencer by one request and return the outputs it gives
  task automatic sequencer_step(input host_req_t rq, output rsp_t r);
    phase_t p;
    bit     spent;
    r = '0;
    p = seq_phase;
    if (rq.func == FUNC_START) begin
      // a start is ignored while busy or with an unknown op
      if (p != PH_IDLE) begin
        r.cs_low = card_selected(p);
        r.busy_res = 1'b1;
        return;
      end
      if (rq.op > OP_WRITE) return;
      seq_op = rq.op;
      seq_addr = {rq.sector, 9'd0};
      ocr_last = '0;
      case (rq.op)
        OP_RESET: enter_phase(PH_WARM);
        OP_CHECK: enter_phase(PH_CMD8);
        OP_INIT:  enter_phase(PH_PRE3);
        OP_READ:  enter_phase(PH_CMD17);
        default:  enter_phase(PH_LEAD);
      endcase
    end else begin
      if (p == PH_IDLE) return;
      if (step_len(p) != '0) begin
        if (p == PH_OCR) ocr_last = rq.rx_byte;
        if (p == PH_RDATA) begin
          r.rd_valid = 1'b1;
          r.rd_byte = rq.rx_byte;
          r.rd_last = (seq_count == LAST_DATA);
        end
        seq_count = seq_count + 10'd1;
        if (seq_count >= step_len(p)) begin
          enter_phase(step_after(p));
          if (seq_phase == PH_IDLE) begin
            r.done_res = 1'b1;
            r.result_byte = (seq_op == OP_CHECK) ? ocr_last : '0;
            return;
          end
        end
      end else begin
        // reply polling
        case (p)
          PH_R0:     if (rq.rx_byte == R1_IDLE) enter_phase(PH_TAIL2);
          PH_R8:     if (rq.rx_byte == R1_IDLE) enter_phase(PH_GAP9);
          PH_R58:    if (rq.rx_byte != BYTE_IDLE) enter_phase(PH_OCR);
          PH_R24:    if (rq.rx_byte == R1_READY) enter_phase(PH_GAP5);
          PH_BUSY:   if (rq.rx_byte == BYTE_IDLE) enter_phase(PH_TAIL2);
          PH_WAITFE: if (rq.rx_byte == TOKEN_START) enter_phase(PH_RDATA);
          PH_R55: begin
            spent = poll_spent();
            if (spent || rq.rx_byte == R1_IDLE) enter_phase(PH_ACMD41);
          end
          PH_R41: begin
            if (rq.rx_byte == R1_READY) enter_phase(PH_TAIL2);
            else if (poll_spent()) enter_phase(PH_CMD55);
          end
          PH_R17: begin
            spent = poll_spent();
            if (spent || rq.rx_byte != BYTE_IDLE)
              enter_phase(rq.rx_byte == R1_READY ? PH_WAITFE : PH_CMD17);
          end
          default: begin
            enter_phase(PH_IDLE);
            return;
          end
        endcase
      end
    end
    r.tx_valid = 1'b1;
    r.tx_byte = out_byte(seq_phase, seq_count, seq_addr, rq.wr_byte);
    r.cs_low = card_selected(seq_phase);
    r.data_request = (seq_phase == PH_TOKEN) ||
                     (seq_phase == PH_WDATA && seq_count < LAST_DATA);
    r.busy_res = 1'b1;
  endtask

  // card answer: the awaited byte at pct percent, else a likely miss or noise
  function automatic logic [7:0] poll_reply(logic [7:0] awaited, logic [7:0] miss, int pct);
    int x;
    x = $urandom_range(99);
    if (x < pct) return awaited;
    if (x < pct + (100 - pct) / 2) return miss;
    return 8'($urandom);
  endfunction

  task automatic add_row(input logic f, input logic [2:0] o, input logic [22:0] s,
                         input logic [7:0] rx, input logic [7:0] wr, input bit typed,
                         input rsp_t want);
    step_row_t row;
    row.rq = '{f, o, s, rx, wr};
    row.typed = typed;
    row.want = want;
    rows.push_back(row);
  endtask

  // drive one request in bursts, wait for it to be taken, then predict it
  task automatic offer(input host_req_t rq, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(2) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 10);
    end
    burst_left--;
    req_valid <= 1'b1;
    func      <= rq.func;
    op        <= rq.op;
    sector    <= rq.sector;
    rx_byte   <= rq.rx_byte;
    wr_byte   <= rq.wr_byte;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sequencer_step(rq, predicted);
    host_out_q.push_back(typed ? want : predicted);
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] seen,
                             input logic [7:0] wanted);
    if (seen !== wanted)
      report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
                                result_no, name, seen, wanted));
  endtask

  // receiver stall pattern: windows of random length with their own stall rate
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(20, 200);
      case ($urandom_range(3))
        0:       stall_pct <= 0;
        1:       stall_pct <= 20;
        2:       stall_pct <= 50;
        default: stall_pct <= 80;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : check_results
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = {tx_valid, tx_byte, cs_low, data_request, rd_valid, rd_byte, rd_last,
             done_res, result_byte, busy_res};
      if (host_out_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_no));
      end else begin
        want = host_out_q.pop_front();
        check_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
        check_field("tx_byte", got.tx_byte, want.tx_byte);
        check_field("cs_low", 8'(got.cs_low), 8'(want.cs_low));
        check_field("data_request", 8'(got.data_request), 8'(want.data_request));
        check_field("rd_valid", 8'(got.rd_valid), 8'(want.rd_valid));
        check_field("rd_byte", got.rd_byte, want.rd_byte);
        check_field("rd_last", 8'(got.rd_last), 8'(want.rd_last));
        check_field("done_res", 8'(got.done_res), 8'(want.done_res));
        check_field("result_byte", got.result_byte, want.result_byte);
        check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      end
      result_no++;
    end
  end

  initial begin : stimulus
    host_req_t  rq;
    logic [2:0] op_sel;
    logic [7:0] lim;
    logic [7:0] rx;
    logic [22:0] sec;
    int         setting;
    int         op_no;
    int         x;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: idle noise, unknown ops, an init with a busy start and a slow card
    add_row(FUNC_BYTE, OP_NONE_LAST, '1, 8'hff, 8'hff, 1'b1, '0);
    add_row(FUNC_START, OP_NONE_FIRST, '1, 8'h00, 8'h00, 1'b1, '0);
    add_row(FUNC_START, OP_NONE_LAST, '0, 8'h80, 8'h7f, 1'b1, '0);
    add_row(FUNC_START, OP_INIT, '1, 8'hff, 8'h00, 1'b1,
            rsp_t'{tx_valid: 1'b1, tx_byte: BYTE_IDLE, busy_res: 1'b1, default: '0});
    add_row(FUNC_START, OP_WRITE, '0, 8'h00, 8'hff, 1'b1,
            rsp_t'{busy_res: 1'b1, default: '0});
    for (int i = 0; i < 9; i++)
      add_row(FUNC_BYTE, OP_RESET, '0, 8'(i * 37), 8'hff ^ 8'(i), 1'b0, '0);
    add_row(FUNC_BYTE, OP_CHECK, '1, BYTE_IDLE, 8'h00, 1'b0, '0);
    add_row(FUNC_START, OP_RESET, '1, 8'h00, 8'h00, 1'b1,
            rsp_t'{cs_low: 1'b1, busy_res: 1'b1, default: '0});
    add_row(FUNC_BYTE, OP_READ, '0, R1_IDLE, 8'h55, 1'b0, '0);
    for (int i = 0; i < 6; i++)
      add_row(FUNC_BYTE, OP_WRITE, '1, 8'(8'h80 >> i), 8'(i), 1'b0, '0);
    add_row(FUNC_BYTE, OP_RESET, '0, 8'h05, 8'haa, 1'b0, '0);
    add_row(FUNC_BYTE, OP_RESET, '0, R1_READY, 8'h00, 1'b0, '0);
    add_row(FUNC_BYTE, OP_RESET, '0, 8'h7f, 8'hff, 1'b0, '0);
    add_row(FUNC_BYTE, OP_RESET, '0, 8'hff, 8'h00, 1'b1, rsp_t'{done_res: 1'b1, default: '0});
    foreach (rows[i]) offer(rows[i].rq, rows[i].typed, rows[i].want);

    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      // block idle and drained: rewrite the poll limit
      req_valid <= 1'b0;
      @(posedge clk);
      while (host_out_q.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      lim = (setting == NUM_SETTINGS - 1) ? 8'($urandom_range(3, 254)) : LIMIT_STEPS[setting];
      cfg_we   <= 1'b1;
      cfg_data <= lim;
      @(posedge clk);
      cfg_we <= 1'b0;
      model_poll_limit = lim;

      op_no = 0;
      while (op_no < 2 || fed_items < (setting + 1) * ITEMS / NUM_SETTINGS) begin
        // ignored while idle: a byte done, or a start with an unknown op
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1) == 1)
            rq = '{FUNC_BYTE, 3'($urandom), 23'($urandom), 8'($urandom), 8'($urandom)};
          else
            rq = '{FUNC_START, 3'($urandom_range(OP_NONE_LAST, OP_NONE_FIRST)),
                   23'($urandom), 8'($urandom), 8'($urandom)};
          offer(rq, 1'b0, '0);
        end

        // sector transfers are long, so they are rare apart from the forced ones
        x = $urandom_range(99);
        if (op_no == 0 && setting == 0) op_sel = OP_WRITE;
        else if (op_no == 0 && setting == 1) op_sel = OP_READ;
        else if (op_no == 1) op_sel = OP_INIT;
        else if (x < 25) op_sel = OP_RESET;
        else if (x < 55) op_sel = OP_CHECK;
        else if (x < 90) op_sel = OP_INIT;
        else if (x < 95) op_sel = OP_READ;
        else op_sel = OP_WRITE;

        x = $urandom_range(9);
        sec = (x == 0) ? '0 : (x == 1) ? '1 : 23'($urandom);
        rq = '{FUNC_START, op_sel, sec, 8'($urandom), 8'($urandom)};
        offer(rq, 1'b0, '0);
        fed_items++;

        // play the card until the operation finishes
        while (seq_phase != PH_IDLE) begin
          if ($urandom_range(99) < 3) begin
            rq = '{FUNC_START, 3'($urandom), 23'($urandom), 8'($urandom), 8'($urandom)};
            offer(rq, 1'b0, '0);
          end
          case (seq_phase)
            PH_R0, PH_R8: rx = poll_reply(R1_IDLE, BYTE_IDLE, 40);
            PH_R55:       rx = poll_reply(R1_IDLE, BYTE_IDLE, 50);
            PH_R41:       rx = poll_reply(R1_READY, R1_IDLE, 30);
            PH_R24:       rx = poll_reply(R1_READY, BYTE_IDLE, 40);
            PH_R17:       rx = poll_reply(R1_READY, BYTE_IDLE, 30);
            PH_R58:       rx = poll_reply(BYTE_IDLE, BYTE_IDLE, 50);
            PH_WAITFE:    rx = poll_reply(TOKEN_START, BYTE_IDLE, 35);
            PH_BUSY:      rx = poll_reply(BYTE_IDLE, R1_READY, 35);
            default:      rx = 8'($urandom);
          endcase
          rq = '{FUNC_BYTE, 3'($urandom), 23'($urandom), rx, 8'($urandom)};
          offer(rq, 1'b0, '0);
          fed_items++;
        end
        op_no++;
      end
    end

    // drain and give stray results time to show up
    req_valid <= 1'b0;
    @(posedge clk);
    while (host_out_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results pending", host_out_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sdspi_pkg.sv
sv/sdspi_fsm.sv
sv/sd_card_spi_mode_host_sequencer.sv
sim/tb_top.sv
